@@ rtl/core/fixed_point_alu_assert.svh @@
// assertion macros for the fixed-point alu
// no dependencies; included by the top level
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// consequent must hold whenever antecedent holds
`define FPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition must never be true
`define FPA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

@@ rtl/core/fpa_pkg.sv @@
// types, codes and saturation helper for the fixed-point alu
// no dependencies
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_FROM_INT = 4'd14,
    KIND_TO_INT   = 4'd15
  } kind_e;

  localparam int QuoBits = 33;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               overflowed;
    logic               divide_by_zero;
  } out_word_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] value;
  } sat_t;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        res;
    logic               cmp;
    logic               ovf;
    logic               dz;
    logic               neg;
    logic               dovf;
    logic signed [63:0] prod;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [63:0]         rem;
    logic [31:0]         den;
    logic [QuoBits-1:0]  quo;
  } div_t;

  // saturate a magnitude with sign into the signed 32-bit range
  function automatic sat_t sat_mag(input logic [63:0] mag, input logic neg);
    sat_t s;
    if (!neg) begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        s.ovf   = 1'b1;
        s.value = 32'h7fff_ffff;
      end else begin
        s.ovf   = 1'b0;
        s.value = mag[31:0];
      end
    end else begin
      if (mag > 64'h0000_0000_8000_0000) begin
        s.ovf   = 1'b1;
        s.value = 32'h8000_0000;
      end else begin
        s.ovf   = 1'b0;
        s.value = (~mag[31:0]) + 32'd1;
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fixed_point_alu.sv @@
// pipeline from input word to output word: input register, operand stage,
// 33 divider steps of one quotient bit each, output stage
// throughput: one word per cycle; a stall at the output holds the whole pipeline
// reset clears all stage valid bits; data registers are not reset
`default_nettype none
`include "fixed_point_alu_assert.svh"
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_word_t out_word_o
);

  logic     en;
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     stg_valid [QuoBits+1];
  div_t     stg_div   [QuoBits+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_word_q <= in_word_i;
    end
  end

  fpa_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .word_i  (in_word_q),
    .valid_o (stg_valid[0]),
    .div_o   (stg_div[0])
  );

  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    fpa_div_step #(.SHIFT(QuoBits - 1 - g)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stg_valid[g]),
      .div_i   (stg_div[g]),
      .valid_o (stg_valid[g+1]),
      .div_o   (stg_div[g+1])
    );
  end

  fpa_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (stg_valid[QuoBits]),
    .div_i   (stg_div[QuoBits]),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

  `FPA_ASSERT_IMPL(a_dz_zero, clk_i, rst_ni,
    out_valid_o && out_word_o.divide_by_zero,
    out_word_o.result_value == 32'sd0 && !out_word_o.overflowed)
  `FPA_ASSERT_NEVER(a_cmp_ovf, clk_i, rst_ni,
    out_valid_o && out_word_o.compare_true && out_word_o.overflowed)
  `FPA_ASSERT_IMPL(a_cmp_res, clk_i, rst_ni,
    out_valid_o && out_word_o.compare_true, out_word_o.result_value == 32'sd0)

endmodule
`default_nettype wire

@@ rtl/core/fpa_prep.sv @@
// operand stage: simple ops, magnitudes, divider setup and the multiplier
// depends on fpa_pkg
`default_nettype none
module fpa_prep import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      en_i,
  input  wire      valid_i,
  input  in_word_t word_i,
  output logic     valid_o,
  output div_t     div_o
);

  function automatic sat_t sat33(input logic [32:0] s);
    sat_t r;
    if (s[32] != s[31]) begin
      r.ovf   = 1'b1;
      r.value = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.ovf   = 1'b0;
      r.value = s[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] a, b;
  logic [32:0]        a33, b33;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        num;
  sat_t               sat_r;
  logic               cmp_r;
  div_t               div_d;
  logic               valid_q;
  div_t               div_q;

  assign a     = word_i.operand_a;
  assign b     = word_i.operand_b;
  assign a33   = {a[31], a};
  assign b33   = {b[31], b};
  assign mag_a = a[31] ? (~a) + 32'd1 : a;
  assign mag_b = b[31] ? (~b) + 32'd1 : b;
  assign num   = {32'd0, mag_a} << FRACTION_BITS;

  always_comb begin
    sat_r = '0;
    cmp_r = 1'b0;
    case (word_i.kind)
      KIND_ADD:      sat_r = sat33(a33 + b33);
      KIND_SUB:      sat_r = sat33(a33 - b33);
      KIND_MUL:      sat_r = '0;
      KIND_DIV:      sat_r = '0;
      KIND_GT:       cmp_r = a > b;
      KIND_LT:       cmp_r = a < b;
      KIND_GE:       cmp_r = a >= b;
      KIND_LE:       cmp_r = a <= b;
      KIND_EQ:       cmp_r = a == b;
      KIND_NE:       cmp_r = a != b;
      KIND_MIN:      sat_r.value = (a < b) ? a : b;
      KIND_MAX:      sat_r.value = (a > b) ? a : b;
      KIND_INC:      sat_r = sat33(a33 + 33'd1);
      KIND_DEC:      sat_r = sat33(a33 - 33'd1);
      KIND_FROM_INT: sat_r = sat_mag(num, a[31]);
      KIND_TO_INT:   sat_r.value = a >>> FRACTION_BITS;
      default:       sat_r = '0;
    endcase
  end

  always_comb begin
    div_d.side.kind = word_i.kind;
    div_d.side.res  = sat_r.value;
    div_d.side.cmp  = cmp_r;
    div_d.side.ovf  = sat_r.ovf;
    div_d.side.dz   = (word_i.kind == KIND_DIV) && (b == 32'sd0);
    div_d.side.neg  = a[31] ^ b[31];
    // quotient would not fit in the divider width: saturates anyway
    div_d.side.dovf = {1'b0, num} >= ({33'd0, mag_b} << QuoBits);
    div_d.side.prod = a * b;
    div_d.rem       = num;
    div_d.den       = mag_b;
    div_d.quo       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

@@ rtl/core/fpa_div_step.sv @@
// one restoring division step producing one quotient bit, registered
// depends on fpa_pkg
`default_nettype none
module fpa_div_step import fpa_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  en_i,
  input  wire  valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic [63:0] den_sh;
  div_t        div_d;
  logic        valid_q;
  div_t        div_q;

  assign den_sh = {32'd0, div_i.den} << SHIFT;

  always_comb begin
    div_d = div_i;
    if (div_i.rem >= den_sh) begin
      div_d.rem        = div_i.rem - den_sh;
      div_d.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

@@ rtl/core/fpa_post.sv @@
// output stage: rounding and saturation of multiply and divide, result select
// depends on fpa_pkg
`default_nettype none
module fpa_post import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       en_i,
  input  wire       valid_i,
  input  div_t      div_i,
  output logic      valid_o,
  output out_word_t word_o
);

  localparam logic [63:0] Half = 64'd1 << (FRACTION_BITS - 1);

  logic [63:0] mul_mag, mul_q, div_qr;
  logic        div_rnd;
  sat_t        mul_s, div_s;
  out_word_t   word_d;
  logic        valid_q;
  out_word_t   word_q;

  assign mul_mag = div_i.side.prod[63] ? (~div_i.side.prod) + 64'd1 : div_i.side.prod;
  assign mul_q   = (mul_mag + Half) >> FRACTION_BITS;
  assign mul_s   = sat_mag(mul_q, div_i.side.prod[63]);

  // round half up on the remainder
  assign div_rnd = {div_i.rem[31:0], 1'b0} >= {1'b0, div_i.den};
  assign div_qr  = {31'd0, div_i.quo} + {63'd0, div_rnd};

  always_comb begin
    if (div_i.side.dovf) begin
      div_s.ovf   = 1'b1;
      div_s.value = div_i.side.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      div_s = sat_mag(div_qr, div_i.side.neg);
    end
  end

  always_comb begin
    word_d.result_value   = div_i.side.res;
    word_d.compare_true   = div_i.side.cmp;
    word_d.overflowed     = div_i.side.ovf;
    word_d.divide_by_zero = 1'b0;
    if (div_i.side.kind == KIND_MUL) begin
      word_d.result_value = mul_s.value;
      word_d.overflowed   = mul_s.ovf;
    end else if (div_i.side.kind == KIND_DIV) begin
      if (div_i.side.dz) begin
        word_d.result_value   = '0;
        word_d.overflowed     = 1'b0;
        word_d.divide_by_zero = 1'b1;
      end else begin
        word_d.result_value = div_s.value;
        word_d.overflowed   = div_s.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for fixed_point_alu: directed table and random words, each
// result checked against a behavioral predictor or its row; uses fpa_pkg and the rtl
`default_nettype none
module tb;
  import fpa_pkg::*;

  localparam int FracBits = 8;
  localparam int Latency = 36;
  localparam int RandWords = 630;
  localparam int CycleLimit = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;

  out_word_t expected_q[$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  bit sending_done;

  fixed_point_alu #(.FRACTION_BITS(FracBits)) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_word_t saturate(input logic signed [95:0] v);
    out_word_t w;
    w = '0;
    if (v > 96'sh7fff_ffff) begin
      w.result_value = 32'sh7fff_ffff;
      w.overflowed = 1'b1;
    end else if (v < -96'sh8000_0000) begin
      w.result_value = 32'sh8000_0000;
      w.overflowed = 1'b1;
    end else begin
      w.result_value = v[31:0];
    end
    return w;
  endfunction

  function automatic out_word_t alu_result(input in_word_t w);
    logic signed [95:0] a;
    logic signed [95:0] b;
    logic signed [95:0] p;
    logic [95:0] m;
    logic [95:0] n;
    logic [95:0] d;
    logic [95:0] q;
    logic neg;
    out_word_t r;
    a = w.operand_a;
    b = w.operand_b;
    r = '0;
    case (w.kind)
      KIND_ADD: r = saturate(a + b);
      KIND_SUB: r = saturate(a - b);
      KIND_MUL: begin
        p = a * b;
        neg = p < 0;
        m = neg ? -p : p;
        q = (m + (96'd1 << (FracBits - 1))) >> FracBits;
        r = saturate(neg ? -$signed(q) : $signed(q));
      end
      KIND_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          neg = (a < 0) != (b < 0);
          n = (a < 0 ? -a : a) << FracBits;
          d = b < 0 ? -b : b;
          q = (2 * n + d) / (2 * d);
          r = saturate(neg ? -$signed(q) : $signed(q));
        end
      end
      KIND_GT: r.compare_true = a > b;
      KIND_LT: r.compare_true = a < b;
      KIND_GE: r.compare_true = a >= b;
      KIND_LE: r.compare_true = a <= b;
      KIND_EQ: r.compare_true = a == b;
      KIND_NE: r.compare_true = a != b;
      KIND_MIN: r.result_value = (a < b) ? w.operand_a : w.operand_b;
      KIND_MAX: r.result_value = (a > b) ? w.operand_a : w.operand_b;
      KIND_INC: r = saturate(a + 1);
      KIND_DEC: r = saturate(a - 1);
      KIND_FROM_INT: r = saturate(a <<< FracBits);
      default: r.result_value = w.operand_a >>> FracBits;
    endcase
    return r;
  endfunction

  task automatic send_word(input in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    expected_q.push_back(alu_result(w));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(1023) - 512;
      3: return 32'($signed($urandom_range(4095)) - 2048) <<< FracBits;
      4: return $urandom_range(1) ? 32'(0) : 32'($urandom_range(65535));
      default: return $urandom;
    endcase
  endfunction

  // directed words; a checked value means the row carries its own expectation
  typedef struct {
    in_word_t w;
    bit checked;
    out_word_t exp;
  } row_t;

  row_t rows[] = '{
    '{'{KIND_ADD, 32'sh7fff_ffff, 32'sd1}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_SUB, 32'sh8000_0000, 32'sd1}, 1, '{32'sh8000_0000, 0, 1, 0}},
    '{'{KIND_MUL, 32'sh0000_0180, 32'sh0000_0080}, 0, '0},
    '{'{KIND_MUL, -32'sh0000_0180, 32'sh0000_0080}, 0, '0},
    '{'{KIND_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_MUL, 32'sh8000_0000, 32'sh8000_0000}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_DIV, 32'sd5, 32'sd0}, 1, '{32'sd0, 0, 0, 1}},
    '{'{KIND_DIV, 32'sh8000_0000, -32'sd1}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_DIV, 32'sd1, 32'sd512}, 0, '0},
    '{'{KIND_DIV, -32'sd1, 32'sd512}, 0, '0},
    '{'{KIND_DIV, 32'sh8000_0000, 32'sh7fff_ffff}, 0, '0},
    '{'{KIND_GT, 32'sd3, 32'sd2}, 1, '{32'sd0, 1, 0, 0}},
    '{'{KIND_LT, 32'sh8000_0000, 32'sh7fff_ffff}, 1, '{32'sd0, 1, 0, 0}},
    '{'{KIND_GE, 32'sd2, 32'sd2}, 1, '{32'sd0, 1, 0, 0}},
    '{'{KIND_LE, 32'sd3, 32'sd2}, 1, '{32'sd0, 0, 0, 0}},
    '{'{KIND_EQ, -32'sd1, -32'sd1}, 1, '{32'sd0, 1, 0, 0}},
    '{'{KIND_NE, -32'sd1, -32'sd1}, 1, '{32'sd0, 0, 0, 0}},
    '{'{KIND_MIN, 32'sh8000_0000, 32'sh7fff_ffff}, 1, '{32'sh8000_0000, 0, 0, 0}},
    '{'{KIND_MAX, 32'sh8000_0000, 32'sh7fff_ffff}, 1, '{32'sh7fff_ffff, 0, 0, 0}},
    '{'{KIND_INC, 32'sh7fff_ffff, 32'hffff_ffff}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_DEC, 32'sh8000_0000, 32'sd0}, 1, '{32'sh8000_0000, 0, 1, 0}},
    '{'{KIND_FROM_INT, 32'sh0080_0000, 32'sd0}, 1, '{32'sh7fff_ffff, 0, 1, 0}},
    '{'{KIND_FROM_INT, -32'sd3, 32'sd0}, 1, '{-32'sd768, 0, 0, 0}},
    '{'{KIND_TO_INT, -32'sd1, 32'sd0}, 1, '{-32'sd1, 0, 0, 0}},
    '{'{KIND_TO_INT, 32'sh7fff_ffff, 32'sd0}, 1, '{32'sh007f_ffff, 0, 0, 0}}
  };

  initial begin
    in_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    mismatches = 0;
    sending_done = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 69;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].checked) expected_q[$] = rows[i].exp;
    end
    for (int i = 0; i < RandWords; i++) begin
      if (i == RandWords / 3) begin
        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
        send_idle_pct = 69;
        recv_idle_pct = 24;
      end else if (i == 2 * RandWords / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w.kind = kind_e'($urandom_range(15));
      w.operand_a = rand_operand();
      w.operand_b = rand_operand();
      send_word(w);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        out_word_t e;
        e = expected_q.pop_front();
        if (out_word !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h got %h", e, out_word);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    fork
      begin
        wait (sending_done && expected_q.size() == 0);
        repeat (Latency + 10) @(posedge clk);
      end
      while (cycles < CycleLimit) begin
        @(posedge clk);
        cycles++;
      end
    join_any
    if (cycles < CycleLimit && mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_prep.sv
rtl/core/fpa_div_step.sv
rtl/core/fpa_post.sv
rtl/core/fixed_point_alu.sv
tb/tb.sv
